// File: rtl/mlpd_pkg.sv
// Package for the magic/length page deframer.
// Holds shared types, codes and reset constants; no dependencies.
package mlpd_pkg;

    localparam int LEN_W   = 24;
    localparam int SHIFT_W = 32;
    localparam int HC_W    = 4;
    localparam int LENGTH_BYTES = 4;

    localparam logic [LEN_W-1:0] LEN_MAX24        = 24'hFFFFFF;
    localparam logic [63:0]      MAGIC_RESET      = 64'h7072696D6C696665;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 24'd1048576;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_TOO_LARGE = 2'd3
    } kind_t;

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic {
        CFG_MAGIC_WORD      = 1'b0,
        CFG_MAX_PAGE_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       payload_byte;
        logic             last_of_page;
        logic [LEN_W-1:0] page_length;
    } result_t;

endpackage

// File: rtl/mlpd_out_buf.sv
// Two-entry result buffer (head plus skid) for the page deframer.
// Depends on mlpd_pkg for the result record type.
module mlpd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  mlpd_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output mlpd_pkg::result_t out_data
);
    import mlpd_pkg::*;

    result_t    head_reg;
    result_t    head_next;
    result_t    skid_reg;
    result_t    skid_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (push_valid)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push_valid && pop)
                begin
                    head_next = push_data;
                end
                else if (push_valid)
                begin
                    skid_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next  = skid_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/magic_length_page_deframer.sv
// Top level of the magic/length page deframer.
// Depends on mlpd_pkg and mlpd_out_buf.
//
// Input channel (in_valid/in_stall): operation and rx_byte, one transaction
// per byte. operation 0 carries a received byte, 1 starts a connection and
// clears the parse state. Each page is MAGIC_BYTES magic bytes, a 4-byte
// big-endian length and that many payload bytes.
// Output channel (out_valid/out_stall): one transaction per payload byte,
// per empty page, or per header error (bad magic, page too large).
// Config channel (cfg_valid/cfg_ready): cfg_index selects the magic word or
// the maximum page length; cfg_ready is always high.
// Throughput: one input byte per cycle while in_stall is low; the parse update
// feeds a two-entry output buffer. A result is registered into the buffer head,
// or into the skid entry while the head is held, before it is visible.
// Reset clears the parse state and the buffer and loads the register
// defaults. When the receiver stalls, results collect in the buffer; in_stall
// rises only once both entries are held.
module magic_length_page_deframer #(
    parameter int MAGIC_BYTES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     operation,
    input  logic [7:0]               rx_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               result_kind,
    output logic [7:0]               payload_byte,
    output logic                     last_of_page,
    output logic [mlpd_pkg::LEN_W-1:0] page_length,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [63:0]              cfg_data
);
    import mlpd_pkg::*;

    localparam int HDR_LEN = MAGIC_BYTES + LENGTH_BYTES;

    logic [63:0]        magic_word_reg;
    logic [LEN_W-1:0]   max_len_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [HC_W-1:0]    hc_reg;
    logic [HC_W-1:0]    hc_next;
    logic               magic_ok_reg;
    logic               magic_ok_next;
    logic [SHIFT_W-1:0] shift_reg;
    logic [SHIFT_W-1:0] shift_next;
    logic [LEN_W-1:0]   left_reg;
    logic [LEN_W-1:0]   left_next;
    logic [LEN_W-1:0]   declared_reg;
    logic [LEN_W-1:0]   declared_next;

    logic               in_acc;
    logic               push;
    result_t            res;
    result_t            out_res;
    logic               buf_full;

    logic [2:0]         magic_idx;
    logic [7:0]         want_byte;
    logic               ok_hdr;
    logic [SHIFT_W-1:0] shift_hdr;
    logic [LEN_W-1:0]   sat_len;
    logic [LEN_W-1:0]   left_dec;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_acc    = in_valid && !in_stall;

    assign magic_idx = 3'(MAGIC_BYTES - 1) - hc_reg[2:0];
    assign want_byte = magic_word_reg[{magic_idx, 3'b000} +: 8];
    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        ok_hdr    = magic_ok_reg;
        shift_hdr = shift_reg;
        if (hc_reg < HC_W'(MAGIC_BYTES))
        begin
            if (want_byte != rx_byte)
            begin
                ok_hdr = 1'b0;
            end
        end
        else
        begin
            shift_hdr = {shift_reg[SHIFT_W-9:0], rx_byte};
        end
        sat_len = (shift_hdr[SHIFT_W-1:LEN_W] != '0) ? LEN_MAX24 : shift_hdr[LEN_W-1:0];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        hc_next       = hc_reg;
        magic_ok_next = magic_ok_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        declared_next = declared_reg;
        push          = 1'b0;
        res           = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, last_of_page: 1'b0,
                          page_length: declared_reg};
        if (in_acc)
        begin
            if (op_t'(operation) == OP_START)
            begin
                phase_next    = PH_HEADER;
                hc_next       = '0;
                magic_ok_next = 1'b1;
                shift_next    = '0;
                left_next     = '0;
                declared_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        push      = 1'b1;
                        res.payload_byte = rx_byte;
                        res.last_of_page = (left_dec == '0);
                        if (left_dec == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (hc_reg == HC_W'(HDR_LEN - 1))
                        begin
                            hc_next       = '0;
                            magic_ok_next = 1'b1;
                            shift_next    = '0;
                            if (!ok_hdr)
                            begin
                                phase_next      = PH_ERROR;
                                declared_next   = sat_len;
                                push            = 1'b1;
                                res.kind        = KIND_BAD_MAGIC;
                                res.page_length = sat_len;
                            end
                            else if (shift_hdr > {{(SHIFT_W-LEN_W){1'b0}}, max_len_reg})
                            begin
                                phase_next      = PH_ERROR;
                                declared_next   = sat_len;
                                push            = 1'b1;
                                res.kind        = KIND_TOO_LARGE;
                                res.page_length = sat_len;
                            end
                            else if (shift_hdr == '0)
                            begin
                                declared_next    = '0;
                                left_next        = '0;
                                push             = 1'b1;
                                res.kind         = KIND_EMPTY;
                                res.last_of_page = 1'b1;
                                res.page_length  = '0;
                            end
                            else
                            begin
                                declared_next = shift_hdr[LEN_W-1:0];
                                left_next     = shift_hdr[LEN_W-1:0];
                                phase_next    = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            hc_next       = hc_reg + 1'b1;
                            magic_ok_next = ok_hdr;
                            shift_next    = shift_hdr;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hc_reg       <= '0;
            magic_ok_reg <= 1'b1;
            shift_reg    <= '0;
            left_reg     <= '0;
            declared_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hc_reg       <= hc_next;
            magic_ok_reg <= magic_ok_next;
            shift_reg    <= shift_next;
            left_reg     <= left_next;
            declared_reg <= declared_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= MAGIC_RESET;
            max_len_reg    <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAGIC_WORD:      magic_word_reg <= cfg_data;
                CFG_MAX_PAGE_LENGTH: max_len_reg    <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mlpd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push),
        .push_data  (res),
        .full       (buf_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign payload_byte = out_res.payload_byte;
    assign last_of_page = out_res.last_of_page;
    assign page_length  = out_res.page_length;

`ifndef SYNTHESIS
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op_t'(operation) == OP_START) |-> !push)
        else $error("connection start produced a result");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !buf_full)
        else $error("result pushed into full buffer");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && phase_reg == PH_ERROR) |-> !push)
        else $error("result produced in error phase");

    a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.kind == KIND_PAYLOAD && res.last_of_page) |=> phase_reg == PH_HEADER)
        else $error("last payload byte did not return to header phase");
`endif

endmodule

// File: tb/sv/magic_length_page_deframer_test.sv
// Self-checking testbench for magic_length_page_deframer: drives whole, broken,
// oversize and noisy page streams under several register settings and stalls.
// Depends on mlpd_pkg and the deframer RTL; the scoreboard parses bytes itself.
module magic_length_page_deframer_test;
    import mlpd_pkg::*;

    localparam int MAGIC_LEN     = 8;
    localparam int HEADER_LEN    = MAGIC_LEN + LENGTH_BYTES;
    localparam int PHASE_ITEMS   = 230;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;

    class page_tracker;
        logic [63:0]      magic;
        logic [LEN_W-1:0] max_length;
        phase_t           state;
        int unsigned      header_count;
        bit               magic_ok;
        logic [31:0]      length_shift;
        logic [LEN_W-1:0] bytes_left;
        logic [LEN_W-1:0] declared_length;
        result_t          awaited[$];
        int unsigned      failures;

        function new();
            magic      = MAGIC_RESET;
            max_length = MAX_LENGTH_RESET;
            failures   = 0;
            restart();
        endfunction

        function void restart();
            state           = PH_HEADER;
            header_count    = 0;
            magic_ok        = 1'b1;
            length_shift    = '0;
            bytes_left      = '0;
            declared_length = '0;
        endfunction

        function void set_register(cfg_index_t idx, logic [63:0] data);
            if (idx == CFG_MAGIC_WORD)
                magic = data;
            else
                max_length = data[LEN_W-1:0];
        endfunction

        function void push_result(kind_t kind, logic [7:0] data, logic is_last,
                                  logic [LEN_W-1:0] len);
            result_t r;
            r.kind         = kind;
            r.payload_byte = data;
            r.last_of_page = is_last;
            r.page_length  = len;
            awaited.push_back(r);
        endfunction

        // note an accepted input transaction and queue the result it causes
        function void parse_byte(op_t op, logic [7:0] data);
            logic [31:0]      len;
            logic [LEN_W-1:0] capped;
            if (op == OP_START)
            begin
                restart();
                return;
            end
            case (state)
                PH_PAYLOAD:
                begin
                    if (bytes_left != 0)
                        bytes_left--;
                    if (bytes_left == 0)
                        state = PH_HEADER;
                    push_result(KIND_PAYLOAD, data, bytes_left == 0, declared_length);
                end
                PH_HEADER:
                begin
                    if (header_count < MAGIC_LEN)
                    begin
                        if (magic[8*(MAGIC_LEN-1-header_count) +: 8] != data)
                            magic_ok = 1'b0;
                    end
                    else
                        length_shift = {length_shift[23:0], data};
                    header_count++;
                    if (header_count == HEADER_LEN)
                    begin
                        len          = length_shift;
                        capped       = (len > LEN_MAX24) ? LEN_MAX24 : len[LEN_W-1:0];
                        header_count = 0;
                        length_shift = '0;
                        if (!magic_ok)
                        begin
                            state           = PH_ERROR;
                            declared_length = capped;
                            push_result(KIND_BAD_MAGIC, 8'd0, 1'b0, capped);
                        end
                        else if (len > max_length)
                        begin
                            state           = PH_ERROR;
                            declared_length = capped;
                            push_result(KIND_TOO_LARGE, 8'd0, 1'b0, capped);
                        end
                        else if (len == 0)
                        begin
                            declared_length = '0;
                            bytes_left      = '0;
                            push_result(KIND_EMPTY, 8'd0, 1'b1, '0);
                        end
                        else
                        begin
                            declared_length = len[LEN_W-1:0];
                            bytes_left      = len[LEN_W-1:0];
                            state           = PH_PAYLOAD;
                        end
                        magic_ok = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $error("result_kind: expected none, actual %0d", got.kind);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind != want.kind)
            begin
                $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
                failures++;
            end
            if (got.payload_byte != want.payload_byte)
            begin
                $error("payload_byte: expected %0d, actual %0d",
                       want.payload_byte, got.payload_byte);
                failures++;
            end
            if (got.last_of_page != want.last_of_page)
            begin
                $error("last_of_page: expected %0d, actual %0d",
                       want.last_of_page, got.last_of_page);
                failures++;
            end
            if (got.page_length != want.page_length)
            begin
                $error("page_length: expected %0d, actual %0d",
                       want.page_length, got.page_length);
                failures++;
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic             operation    = OP_DATA;
    logic [7:0]       rx_byte      = 8'd0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [1:0]       result_kind;
    logic [7:0]       payload_byte;
    logic             last_of_page;
    logic [LEN_W-1:0] page_length;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic             cfg_index    = CFG_MAGIC_WORD;
    logic [63:0]      cfg_data     = '0;

    page_tracker      tracker;
    bit               calm              = 1'b0;
    int unsigned      hold_off_requests = 0;
    int unsigned      items_sent        = 0;
    logic [63:0]      cur_magic;
    logic [LEN_W-1:0] cur_max;

    magic_length_page_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .last_of_page (last_of_page),
        .page_length  (page_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_register(cfg_index_t'(cfg_index), cfg_data);
            if (in_valid && !in_stall)
                tracker.parse_byte(op_t'(operation), rx_byte);
            if (out_valid && !out_stall)
            begin
                got.kind         = kind_t'(result_kind);
                got.payload_byte = payload_byte;
                got.last_of_page = last_of_page;
                got.page_length  = page_length;
                tracker.check_result(got);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        int unsigned served;
        int unsigned hold_left;
        served    = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && served != hold_off_requests)
            begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    task automatic send_item(op_t op, logic [7:0] data);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_start();
        send_item(OP_START, 8'($urandom_range(0, 255)));
    endtask

    // send the first count bytes of a page: magic, length, then random payload
    task automatic send_page_bytes(logic [63:0] magic_bytes, logic [31:0] len,
                                   int unsigned count);
        logic [7:0] data;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i < MAGIC_LEN)
                data = magic_bytes[8*(MAGIC_LEN-1-i) +: 8];
            else if (i < HEADER_LEN)
                data = len[8*(HEADER_LEN-1-i) +: 8];
            else
                data = 8'($urandom_range(0, 255));
            send_item(OP_DATA, data);
        end
    endtask

    task automatic send_page();
        int unsigned pick;
        int unsigned cap;
        logic [31:0] len;
        logic [31:0] lo;
        logic [63:0] bad;
        pick = $urandom_range(0, 99);
        cap  = (cur_max < 24) ? cur_max : 24;
        lo   = {8'd0, cur_max} + 32'd1;
        if (pick < 70)
        begin
            len = $urandom_range(0, cap);
            send_page_bytes(cur_magic, len, HEADER_LEN + len);
        end
        else if (pick < 78)
        begin
            bad = cur_magic;
            bad[$urandom_range(0, 63)] ^= 1'b1;
            len = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, cap);
            send_page_bytes(bad, len, HEADER_LEN + $urandom_range(0, 3));
            send_start();
        end
        else if (pick < 86)
        begin
            len = ($urandom_range(0, 1) != 0) ? lo : $urandom_range(lo, 32'hFFFF_FFFF);
            send_page_bytes(cur_magic, len, HEADER_LEN + $urandom_range(0, 3));
            send_start();
        end
        else if (pick < 94)
        begin
            len = $urandom_range(0, cap);
            send_page_bytes(cur_magic, len, $urandom_range(1, HEADER_LEN + len));
            send_start();
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                send_item(($urandom_range(0, 7) == 0) ? OP_START : OP_DATA,
                          8'($urandom_range(0, 255)));
            send_start();
        end
    endtask

    // hold the input until every queued result has been taken
    task automatic drain();
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (tracker.awaited.size() != 0)
        begin
            $error("results outstanding: expected 0, actual %0d", tracker.awaited.size());
            tracker.failures++;
            tracker.awaited.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [63:0] magic_bytes, logic [LEN_W-1:0] max_len);
        write_register(CFG_MAGIC_WORD, magic_bytes);
        write_register(CFG_MAX_PAGE_LENGTH, {40'd0, max_len});
        cur_magic = magic_bytes;
        cur_max   = max_len;
    endtask

    initial
    begin
        int unsigned phase_start;
        logic [63:0] magic_set[5];
        logic [LEN_W-1:0] max_set[5];
        tracker   = new();
        cur_magic = MAGIC_RESET;
        cur_max   = MAX_LENGTH_RESET;
        magic_set = '{MAGIC_RESET, 64'd0, {64{1'b1}}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()}};
        max_set   = '{MAX_LENGTH_RESET, '0, LEN_MAX24,
                      LEN_W'($urandom_range(1, 40)), LEN_W'($urandom_range(0, 300))};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty page, then bad magic with an oversize length, a dropped byte and restart
        send_start();
        send_page_bytes(cur_magic, 32'd0, HEADER_LEN);
        send_page_bytes(~cur_magic, 32'hFFFF_FFFF, HEADER_LEN + 1);
        send_start();

        for (int k = 0; k < 5; k++)
        begin
            drain();
            configure(magic_set[k], max_set[k]);
            calm = (k == 4);
            phase_start = items_sent;
            if (k == 2)
            begin
                // stall the receiver during a long page so the input backs up
                hold_off_requests++;
                send_page_bytes(cur_magic, 32'd300, HEADER_LEN + 300);
            end
            while (items_sent < phase_start + PHASE_ITEMS)
            begin
                send_page();
                if (k == 3 && items_sent >= phase_start + PHASE_ITEMS / 2
                    && items_sent < phase_start + PHASE_ITEMS / 2 + 40)
                    drain();
            end
            calm = 1'b0;
        end

        drain();
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
